### hdl/ecpb_pkg.sv
// ----------------------------------------------------------------------------
// ecpb_pkg - shared types and codes of the colour palette builder
// Command and status codes, field widths and the control word that walks
// the cell chain next to each item.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpb_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int COLOUR_W    = 16;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int INDEX_W     = 8;
	localparam int COUNT_W     = 9;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

	// control part of an item in flight through the chain
	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] cmd;
		logic             hit;
	} tok_ctl_t;

endpackage

`default_nettype wire

### hdl/ecpb_cell.sv
// ----------------------------------------------------------------------------
// ecpb_cell - one palette entry of the cell chain
// Holds one colour and its valid bit. An item passing by compares, claims
// the entry on a new insert, or drops it on clear, and picks up the count.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpb_cell
	import ecpb_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int CELL_IDX = 0,
	localparam int IDX_W   = $clog2(ENTRIES),
	localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire tok_ctl_t            ctl_i,
	input  wire logic [COLOUR_W-1:0] colour_i,
	input  wire logic [IDX_W-1:0]    pos_i,
	input  wire logic [CNT_W-1:0]    cnt_i,
	output tok_ctl_t                 ctl_o,
	output logic      [COLOUR_W-1:0] colour_o,
	output logic      [IDX_W-1:0]    pos_o,
	output logic      [CNT_W-1:0]    cnt_o
);

	logic [COLOUR_W-1:0] entry_q;
	logic                vld_q;

	logic                vld_d;
	logic                wr;
	logic                hit_d;
	logic [IDX_W-1:0]    pos_d;
	logic                match;

	assign match = vld_q && (entry_q == colour_i);

	always_comb begin
		vld_d = vld_q;
		wr    = 1'b0;
		hit_d = ctl_i.hit;
		pos_d = pos_i;
		if (ctl_i.valid) begin
			case (ctl_i.cmd)
				CMD_INSERT: begin
					if (!ctl_i.hit) begin
						if (match) begin
							hit_d = 1'b1;
							pos_d = IDX_W'(CELL_IDX);
						end else if (!vld_q) begin
							// first free slot: append here
							wr    = 1'b1;
							vld_d = 1'b1;
							hit_d = 1'b1;
							pos_d = IDX_W'(CELL_IDX);
						end
					end
				end
				CMD_LOOKUP: begin
					if (!ctl_i.hit && match) begin
						hit_d = 1'b1;
						pos_d = IDX_W'(CELL_IDX);
					end
				end
				CMD_CLEAR: begin
					vld_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ctl_o <= '0;
		end else if (en) begin
			vld_q       <= vld_d;
			ctl_o.valid <= ctl_i.valid;
			ctl_o.cmd   <= ctl_i.cmd;
			ctl_o.hit   <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				entry_q <= colour_i;
			end
			colour_o <= colour_i;
			pos_o    <= pos_d;
			cnt_o    <= cnt_i + CNT_W'(vld_d);
		end
	end

endmodule

`default_nettype wire

### hdl/ecpb_out.sv
// ----------------------------------------------------------------------------
// ecpb_out - result register of the palette builder
// Turns the item leaving the chain into status, index and count, and holds
// it until the receiver takes it. Drives the chain advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpb_out
	import ecpb_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int IDX_W  = $clog2(ENTRIES),
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tok_ctl_t            ctl_i,
	input  wire logic [IDX_W-1:0]    pos_i,
	input  wire logic [CNT_W-1:0]    cnt_i,
	output logic                     adv,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [23:0]         m_tdata,
	output logic      [STATUS_W-1:0] m_tuser
);

	logic [STATUS_W-1:0]      status_d;
	logic [IDX_W+INDEX_W-1:0] pos_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic [INDEX_W-1:0]       index_d;
	logic [COUNT_W-1:0]       count_d;
	logic [STATUS_W-1:0]      status_q;
	logic [INDEX_W-1:0]       index_q;
	logic [COUNT_W-1:0]       count_q;

	assign adv = !m_tvalid || m_tready;

	always_comb begin
		status_d = ST_OK;
		if (!ctl_i.hit) begin
			if (ctl_i.cmd == CMD_INSERT) begin
				status_d = ST_FULL;
			end else if (ctl_i.cmd == CMD_LOOKUP) begin
				status_d = ST_MISSING;
			end
		end
	end

	// wide palettes report the low bits only
	assign pos_ext = {{INDEX_W{1'b0}}, pos_i};
	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_i};
	assign index_d = ctl_i.hit ? pos_ext[INDEX_W-1:0] : '0;
	assign count_d = cnt_ext[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			index_q  <= index_d;
			count_q  <= count_d;
		end
	end

	assign m_tuser = status_q;
	assign m_tdata = {7'b0, count_q, index_q};

endmodule

`default_nettype wire

### hdl/exact_colour_palette_builder_core.sv
// ----------------------------------------------------------------------------
// exact_colour_palette_builder_core - palette of distinct 16-bit colours
// Builds a palette in arrival order and maps colours to palette indices.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item per command. s_tuser carries the command
// (insert, lookup, clear), s_tdata the colour. An item is taken on any cycle
// where s_tvalid and s_tready are high.
// Output stream (m_*): one result per item, in order. m_tuser is the status,
// m_tdata holds index (bits 7:0) and entry count after the item (16:8).
// The palette is a chain of ENTRIES cells, one entry each. An item walks
// one cell per cycle while the chain advances, then enters the output
// register; items follow one per cycle while the chain advances.
// Later items trail earlier ones through the chain and always see the
// entries as left by them.
// Reset empties the palette at once; no sweep is needed.
// When the receiver stalls, the output register holds and the whole chain
// freezes; s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module exact_colour_palette_builder_core
	import ecpb_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [COLOUR_W-1:0] s_tdata,  // colour
	input  wire logic [CMD_W-1:0]    s_tuser,  // command
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [23:0]         m_tdata,  // index[7:0], count[16:8], zero
	output logic      [STATUS_W-1:0] m_tuser   // status
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	tok_ctl_t            ctl    [ENTRIES+1];
	logic [COLOUR_W-1:0] colour [ENTRIES+1];
	logic [IDX_W-1:0]    pos    [ENTRIES+1];
	logic [CNT_W-1:0]    cnt    [ENTRIES+1];
	logic                adv;

	assign s_tready     = adv;
	assign ctl[0].valid = s_tvalid && adv;
	assign ctl[0].cmd   = s_tuser;
	assign ctl[0].hit   = 1'b0;
	assign colour[0]    = s_tdata;
	assign pos[0]       = '0;
	assign cnt[0]       = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ecpb_cell #(
			.ENTRIES  (ENTRIES),
			.CELL_IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctl_i    (ctl[i]),
			.colour_i (colour[i]),
			.pos_i    (pos[i]),
			.cnt_i    (cnt[i]),
			.ctl_o    (ctl[i+1]),
			.colour_o (colour[i+1]),
			.pos_o    (pos[i+1]),
			.cnt_o    (cnt[i+1])
		);
	end

	ecpb_out #(
		.ENTRIES (ENTRIES)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_i    (ctl[ENTRIES]),
		.pos_i    (pos[ENTRIES]),
		.cnt_i    (cnt[ENTRIES]),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// an insert that found no match and no free cell means a full palette
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl[ENTRIES].valid && ctl[ENTRIES].cmd == CMD_INSERT && !ctl[ENTRIES].hit)
		|-> (cnt[ENTRIES] == CNT_W'(ENTRIES)))
		else $error("insert missed with free entries left");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl[ENTRIES].valid && ctl[ENTRIES].cmd == CMD_CLEAR)
		|-> (cnt[ENTRIES] == '0))
		else $error("entries left valid after clear");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl[ENTRIES].valid && ctl[ENTRIES].cmd == CMD_INSERT && ctl[ENTRIES].hit)
		|-> (cnt[ENTRIES] > CNT_W'(pos[ENTRIES])))
		else $error("insert hit beyond the filled entries");

endmodule

`default_nettype wire
